// File: rtl/srctok_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// srctok_pkg: shared types, codes and helpers of the source tokenizer
// Token kinds, character codes, scanner modes and the result bundle that
// travels from the scanner through the bundle queue to the emitter.
// ============================================================================
package srctok_pkg;

    // Line counter width and the fixed width of the reported line number
    localparam int LINE_BITS  = 16;
    localparam int LINE_OUT_W = 16;

    // Results one source byte can cause, and the counter/index widths for them
    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    // Bundle queue between scanner and emitter
    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);

    typedef logic [7:0] t_byte;
    typedef logic [4:0] t_kind;
    typedef logic [1:0] t_err;

    // Token kinds
    localparam t_kind K_IDENT   = 5'd0;
    localparam t_kind K_NUMBER  = 5'd1;
    localparam t_kind K_STRING  = 5'd2;
    localparam t_kind K_SEP     = 5'd3;
    localparam t_kind K_LPAREN  = 5'd4;
    localparam t_kind K_RPAREN  = 5'd5;
    localparam t_kind K_LBRACK  = 5'd6;
    localparam t_kind K_RBRACK  = 5'd7;
    localparam t_kind K_LBRACE  = 5'd8;
    localparam t_kind K_RBRACE  = 5'd9;
    localparam t_kind K_COMMA   = 5'd10;
    localparam t_kind K_DOT     = 5'd11;
    localparam t_kind K_COLON   = 5'd12;
    localparam t_kind K_PLUS    = 5'd13;
    localparam t_kind K_MINUS   = 5'd14;
    localparam t_kind K_ARROW   = 5'd15;
    localparam t_kind K_STAR    = 5'd16;
    localparam t_kind K_SLASH   = 5'd17;
    localparam t_kind K_ASSIGN  = 5'd18;
    localparam t_kind K_LT      = 5'd19;
    localparam t_kind K_LE      = 5'd20;
    localparam t_kind K_GT      = 5'd21;
    localparam t_kind K_GE      = 5'd22;
    localparam t_kind K_EOF     = 5'd23;
    localparam t_kind K_UNKNOWN = 5'd24;
    localparam t_kind K_NONE    = 5'd0;

    // Error codes
    localparam t_err ERR_NONE     = 2'd0;
    localparam t_err ERR_STR_NL   = 2'd1;
    localparam t_err ERR_BLOCK_EOF = 2'd2;

    // Character codes
    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_VT     = 8'h0B;
    localparam t_byte CH_FF     = 8'h0C;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_QUOTE  = 8'h22;
    localparam t_byte CH_LPAREN = 8'h28;
    localparam t_byte CH_RPAREN = 8'h29;
    localparam t_byte CH_STAR   = 8'h2A;
    localparam t_byte CH_PLUS   = 8'h2B;
    localparam t_byte CH_COMMA  = 8'h2C;
    localparam t_byte CH_DASH   = 8'h2D;
    localparam t_byte CH_DOT    = 8'h2E;
    localparam t_byte CH_SLASH  = 8'h2F;
    localparam t_byte CH_0      = 8'h30;
    localparam t_byte CH_9      = 8'h39;
    localparam t_byte CH_COLON  = 8'h3A;
    localparam t_byte CH_LT     = 8'h3C;
    localparam t_byte CH_EQ     = 8'h3D;
    localparam t_byte CH_GT     = 8'h3E;
    localparam t_byte CH_UC_A   = 8'h41;
    localparam t_byte CH_UC_Z   = 8'h5A;
    localparam t_byte CH_LBRACK = 8'h5B;
    localparam t_byte CH_BSLASH = 8'h5C;
    localparam t_byte CH_RBRACK = 8'h5D;
    localparam t_byte CH_UNDER  = 8'h5F;
    localparam t_byte CH_LC_A   = 8'h61;
    localparam t_byte CH_LC_N   = 8'h6E;
    localparam t_byte CH_LC_R   = 8'h72;
    localparam t_byte CH_LC_T   = 8'h74;
    localparam t_byte CH_LC_Z   = 8'h7A;
    localparam t_byte CH_LBRACE = 8'h7B;
    localparam t_byte CH_RBRACE = 8'h7D;

    // Scanner modes
    typedef enum logic [4:0] {
        M_IDLE  = 5'd0,
        M_GAP   = 5'd1,
        M_IDENT = 5'd2,
        M_NUM   = 5'd3,
        M_FRAC  = 5'd4,
        M_STR   = 5'd5,
        M_ESC   = 5'd6,
        M_CRTOK = 5'd7,
        M_CRIGN = 5'd8,
        M_DASH  = 5'd9,
        M_LT    = 5'd10,
        M_GT    = 5'd11,
        M_DASH2 = 5'd12,
        M_BR1   = 5'd13,
        M_LINE  = 5'd14,
        M_BLOCK = 5'd15,
        M_BBR   = 5'd16,
        M_BCR   = 5'd17,
        M_ERR   = 5'd18
    } t_mode;

    // One result beat without the end-of-byte mark
    typedef struct packed {
        t_kind                  kind;
        t_byte                  text;
        logic                   text_valid;
        logic                   first;
        logic                   last;
        logic [LINE_OUT_W-1:0]  line;
        t_err                   err;
    } t_result;

    // All results of one source byte
    typedef struct packed {
        t_result [MAX_RES-1:0]  res;
        logic [CNT_W-1:0]       count;
    } t_bundle;

    // Scanner to queue
    typedef struct packed {
        logic    valid;
        t_bundle bun;
    } t_push;

    // Queue head to emitter
    typedef struct packed {
        logic    valid;
        t_bundle bun;
    } t_head;

    function automatic logic is_alpha(t_byte b);
        return (b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z);
    endfunction

    function automatic logic is_digit(t_byte b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic logic is_ws(t_byte b);
        return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF;
    endfunction

    // Single-character punctuation; K_NONE when the byte is not one
    function automatic t_kind punct_kind(t_byte b);
        t_kind k;
        unique case (b)
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACK: k = K_LBRACK;
            CH_RBRACK: k = K_RBRACK;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_COMMA:  k = K_COMMA;
            CH_DOT:    k = K_DOT;
            CH_COLON:  k = K_COLON;
            CH_PLUS:   k = K_PLUS;
            CH_STAR:   k = K_STAR;
            CH_SLASH:  k = K_SLASH;
            CH_EQ:     k = K_ASSIGN;
            default:   k = K_NONE;
        endcase
        return k;
    endfunction

    // Build one result; text is zero when not valid, line saturates
    function automatic t_result mk_res(t_kind kind, t_byte b, logic v, logic first,
                                       logic last, logic [LINE_BITS-1:0] ln, t_err err);
        t_result r;
        logic [LINE_BITS+LINE_OUT_W-1:0] wide;
        wide         = (LINE_BITS + LINE_OUT_W)'(ln);
        r.kind       = kind;
        r.text       = v ? b : 8'h00;
        r.text_valid = v;
        r.first      = first;
        r.last       = last;
        r.line       = (wide > (LINE_BITS + LINE_OUT_W)'({LINE_OUT_W{1'b1}}))
                       ? {LINE_OUT_W{1'b1}} : wide[LINE_OUT_W-1:0];
        r.err        = err;
        return r;
    endfunction

endpackage

// File: rtl/srctok_if.sv
`timescale 1ns / 1ps
// ============================================================================
// srctok_if: channel interfaces of the source tokenizer
// Source bytes in, token character beats out; valid/ready handshake.
// ============================================================================
interface srctok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, data_byte, is_last, input ready);
    modport sink   (input valid, data_byte, is_last, output ready);
endinterface

interface srctok_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [7:0]  text_byte;
    logic        text_valid;
    logic        token_first;
    logic        token_last;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic        run_last;

    modport source (output valid, token_kind, text_byte, text_valid, token_first,
                    token_last, line_number, error_code, run_last, input ready);
    modport sink   (input valid, token_kind, text_byte, text_valid, token_first,
                    token_last, line_number, error_code, run_last, output ready);
endinterface

// File: rtl/srctok_front.sv
`timescale 1ns / 1ps
// ============================================================================
// srctok_front: byte scanner
// Classifies one source byte per cycle while the queue has room, builds the
// bundle of results it causes and holds the token char awaiting its end mark.
// ============================================================================
module srctok_front import srctok_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srctok_in_if.sink     i_in,
    input  logic          i_full,
    output t_push         o_push
);

    t_mode                r_mode, n_mode;
    t_byte                r_hbyte, n_hbyte;
    t_kind                r_hkind, n_hkind;
    logic                 r_hvalid, n_hvalid;
    logic                 r_hfirst, n_hfirst;
    logic [LINE_BITS-1:0] r_line, n_line;

    t_bundle              bun;
    logic                 accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_hbyte  <= '0;
            r_hkind  <= K_IDENT;
            r_hvalid <= 1'b0;
            r_hfirst <= 1'b0;
            r_line   <= LINE_BITS'(1);
        end else if (accept) begin
            r_mode   <= n_mode;
            r_hbyte  <= n_hbyte;
            r_hkind  <= n_hkind;
            r_hvalid <= n_hvalid;
            r_hfirst <= n_hfirst;
            r_line   <= n_line;
        end
    end

    always_comb begin
        t_byte                b;
        logic                 fin;
        t_mode                m;
        t_byte                hb;
        t_kind                hk;
        logic                 hv;
        logic                 hf;
        logic [LINE_BITS-1:0] ln;
        t_result [MAX_RES-1:0] res;
        logic [CNT_W-1:0]     cnt;
        logic                 do_start;
        logic                 do_push;
        t_byte                push_b;
        t_kind                push_k;
        logic                 pf;
        t_kind                pk;

        b        = i_in.data_byte;
        fin      = i_in.is_last;
        m        = r_mode;
        hb       = r_hbyte;
        hk       = r_hkind;
        hv       = r_hvalid;
        hf       = r_hfirst;
        ln       = r_line;
        res      = '0;
        cnt      = '0;
        do_start = 1'b0;
        do_push  = 1'b0;
        push_b   = b;
        push_k   = K_IDENT;
        pf       = 1'b0;
        pk       = K_NONE;

        // ---- byte in the current mode
        unique case (r_mode)
            M_IDENT: begin
                if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
                    do_push = 1'b1;
                    push_k  = K_IDENT;
                end else begin
                    if (hv) begin
                        res[cnt[IDX_W-1:0]] = mk_res(hk, hb, 1'b1, hf, 1'b1, ln, ERR_NONE);
                        cnt = cnt + CNT_W'(1);
                    end
                    hv       = 1'b0;
                    do_start = 1'b1;
                end
            end
            M_NUM, M_FRAC: begin
                if (is_digit(b)) begin
                    do_push = 1'b1;
                    push_k  = K_NUMBER;
                end else if (r_mode == M_NUM && (b == CH_SLASH || b == CH_DOT)) begin
                    do_push = 1'b1;
                    push_k  = K_NUMBER;
                    m       = M_FRAC;
                end else begin
                    if (hv) begin
                        res[cnt[IDX_W-1:0]] = mk_res(hk, hb, 1'b1, hf, 1'b1, ln, ERR_NONE);
                        cnt = cnt + CNT_W'(1);
                    end
                    hv       = 1'b0;
                    do_start = 1'b1;
                end
            end
            M_STR: begin
                if (b == CH_QUOTE) begin
                    if (hv) begin
                        res[cnt[IDX_W-1:0]] = mk_res(hk, hb, 1'b1, hf, 1'b1, ln, ERR_NONE);
                    end else begin
                        res[cnt[IDX_W-1:0]] = mk_res(K_STRING, 8'h00, 1'b0, 1'b1, 1'b1, ln,
                                                     ERR_NONE);
                    end
                    cnt = cnt + CNT_W'(1);
                    hv  = 1'b0;
                    m   = M_IDLE;
                end else if (b == CH_BSLASH) begin
                    m = M_ESC;
                end else if (b == CH_CR || b == CH_LF) begin
                    // send the held char unmarked, then the error beat; drop the rest
                    pf = !hv;
                    if (hv) begin
                        res[cnt[IDX_W-1:0]] = mk_res(hk, hb, 1'b1, hf, 1'b0, ln, ERR_NONE);
                        cnt = cnt + CNT_W'(1);
                    end
                    hv = 1'b0;
                    res[cnt[IDX_W-1:0]] = mk_res(K_STRING, 8'h00, 1'b0, pf, 1'b1, ln,
                                                 ERR_STR_NL);
                    cnt = cnt + CNT_W'(1);
                    m   = M_ERR;
                end else begin
                    do_push = 1'b1;
                    push_k  = K_STRING;
                end
            end
            M_ESC: begin
                push_k = K_STRING;
                m      = M_STR;
                if (b == CH_LC_T) begin
                    do_push = 1'b1;
                    push_b  = CH_TAB;
                end else if (b == CH_LC_N) begin
                    do_push = 1'b1;
                    push_b  = CH_LF;
                end else if (b == CH_LC_R) begin
                    do_push = 1'b1;
                    push_b  = CH_CR;
                end else if (b == CH_BSLASH || b == CH_QUOTE) begin
                    do_push = 1'b1;
                end
            end
            M_CRTOK: begin
                if (b == CH_LF) m = M_IDLE;
                else do_start = 1'b1;
            end
            M_CRIGN: begin
                if (b == CH_LF) m = M_GAP;
                else do_start = 1'b1;
            end
            M_DASH: begin
                if (b == CH_GT) begin
                    res[0] = mk_res(K_ARROW, CH_DASH, 1'b1, 1'b1, 1'b0, ln, ERR_NONE);
                    res[1] = mk_res(K_ARROW, CH_GT, 1'b1, 1'b0, 1'b1, ln, ERR_NONE);
                    cnt    = CNT_W'(2);
                    m      = M_IDLE;
                end else if (b == CH_DASH) begin
                    m = M_DASH2;
                end else begin
                    res[0]   = mk_res(K_MINUS, CH_DASH, 1'b1, 1'b1, 1'b1, ln, ERR_NONE);
                    cnt      = CNT_W'(1);
                    do_start = 1'b1;
                end
            end
            M_LT, M_GT: begin
                if (b == CH_EQ) begin
                    pk     = (r_mode == M_LT) ? K_LE : K_GE;
                    res[0] = mk_res(pk, (r_mode == M_LT) ? CH_LT : CH_GT, 1'b1, 1'b1, 1'b0,
                                    ln, ERR_NONE);
                    res[1] = mk_res(pk, CH_EQ, 1'b1, 1'b0, 1'b1, ln, ERR_NONE);
                    cnt    = CNT_W'(2);
                    m      = M_IDLE;
                end else begin
                    pk       = (r_mode == M_LT) ? K_LT : K_GT;
                    res[0]   = mk_res(pk, (r_mode == M_LT) ? CH_LT : CH_GT, 1'b1, 1'b1,
                                      1'b1, ln, ERR_NONE);
                    cnt      = CNT_W'(1);
                    do_start = 1'b1;
                end
            end
            M_DASH2, M_BR1, M_LINE: begin
                if (r_mode == M_DASH2 && b == CH_LBRACK) begin
                    m = M_BR1;
                end else if (r_mode == M_BR1 && b == CH_LBRACK) begin
                    m = M_BLOCK;
                end else if (b == CH_CR) begin
                    if (ln != {LINE_BITS{1'b1}}) ln = ln + LINE_BITS'(1);
                    m = M_CRIGN;
                end else if (b == CH_LF) begin
                    if (ln != {LINE_BITS{1'b1}}) ln = ln + LINE_BITS'(1);
                    m = M_GAP;
                end else begin
                    m = M_LINE;
                end
            end
            M_BLOCK, M_BBR, M_BCR: begin
                if (r_mode == M_BBR && b == CH_RBRACK) begin
                    m = M_GAP;
                end else if (fin) begin
                    // a final newline inside the comment is not counted
                    m = r_mode;
                end else if (r_mode == M_BCR && b == CH_LF) begin
                    m = M_BLOCK;
                end else if (b == CH_RBRACK) begin
                    m = M_BBR;
                end else if (b == CH_CR) begin
                    if (ln != {LINE_BITS{1'b1}}) ln = ln + LINE_BITS'(1);
                    m = M_BCR;
                end else if (b == CH_LF) begin
                    if (ln != {LINE_BITS{1'b1}}) ln = ln + LINE_BITS'(1);
                    m = M_BLOCK;
                end else begin
                    m = M_BLOCK;
                end
            end
            M_ERR: begin
                m = M_ERR;
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        // ---- start of a new token
        if (do_start) begin
            m = M_IDLE;
            if (is_ws(b)) begin
                m = M_GAP;
            end else if (is_alpha(b)) begin
                do_push = 1'b1;
                push_k  = K_IDENT;
                m       = M_IDENT;
            end else if (is_digit(b)) begin
                do_push = 1'b1;
                push_k  = K_NUMBER;
                m       = M_NUM;
            end else if (b == CH_QUOTE) begin
                hv = 1'b0;
                m  = M_STR;
            end else if (b == CH_CR || b == CH_LF) begin
                res[cnt[IDX_W-1:0]] = mk_res(K_SEP, CH_LF, 1'b1, 1'b1, 1'b1, ln, ERR_NONE);
                cnt = cnt + CNT_W'(1);
                if (ln != {LINE_BITS{1'b1}}) ln = ln + LINE_BITS'(1);
                if (b == CH_CR) m = M_CRTOK;
            end else if (b == CH_DASH) begin
                m = M_DASH;
            end else if (b == CH_LT) begin
                m = M_LT;
            end else if (b == CH_GT) begin
                m = M_GT;
            end else begin
                pk = punct_kind(b);
                if (pk != K_NONE) begin
                    res[cnt[IDX_W-1:0]] = mk_res(pk, b, 1'b1, 1'b1, 1'b1, ln, ERR_NONE);
                end else begin
                    res[cnt[IDX_W-1:0]] = mk_res(K_UNKNOWN, 8'h00, 1'b0, 1'b1, 1'b1,
                                                 LINE_BITS'(0), ERR_NONE);
                end
                cnt = cnt + CNT_W'(1);
            end
        end

        // ---- hold the new token char, send the previous one unmarked
        if (do_push) begin
            pf = !hv;
            if (hv) begin
                res[cnt[IDX_W-1:0]] = mk_res(hk, hb, 1'b1, hf, 1'b0, ln, ERR_NONE);
                cnt = cnt + CNT_W'(1);
            end
            hb = push_b;
            hk = push_k;
            hv = 1'b1;
            hf = pf;
        end

        // ---- end of text closes what is open
        if (fin) begin
            priority case (m)
                M_GAP, M_LINE, M_DASH2, M_BR1, M_CRIGN: begin
                    res[cnt[IDX_W-1:0]] = mk_res(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1, ln,
                                                 ERR_NONE);
                    cnt = cnt + CNT_W'(1);
                end
                M_IDENT, M_NUM, M_FRAC, M_STR, M_ESC: begin
                    if (hv) begin
                        res[cnt[IDX_W-1:0]] = mk_res(hk, hb, 1'b1, hf, 1'b1, ln, ERR_NONE);
                        cnt = cnt + CNT_W'(1);
                    end else if (m == M_STR || m == M_ESC) begin
                        res[cnt[IDX_W-1:0]] = mk_res(K_STRING, 8'h00, 1'b0, 1'b1, 1'b1, ln,
                                                     ERR_NONE);
                        cnt = cnt + CNT_W'(1);
                    end
                end
                M_DASH: begin
                    res[cnt[IDX_W-1:0]] = mk_res(K_MINUS, CH_DASH, 1'b1, 1'b1, 1'b1, ln,
                                                 ERR_NONE);
                    cnt = cnt + CNT_W'(1);
                end
                M_LT: begin
                    res[cnt[IDX_W-1:0]] = mk_res(K_LT, CH_LT, 1'b1, 1'b1, 1'b1, ln, ERR_NONE);
                    cnt = cnt + CNT_W'(1);
                end
                M_GT: begin
                    res[cnt[IDX_W-1:0]] = mk_res(K_GT, CH_GT, 1'b1, 1'b1, 1'b1, ln, ERR_NONE);
                    cnt = cnt + CNT_W'(1);
                end
                M_BLOCK, M_BBR, M_BCR: begin
                    res[cnt[IDX_W-1:0]] = mk_res(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1, ln,
                                                 ERR_BLOCK_EOF);
                    cnt = cnt + CNT_W'(1);
                end
                default: begin
                end
            endcase
            // next text starts from the reset state
            m  = M_IDLE;
            hb = '0;
            hk = K_IDENT;
            hv = 1'b0;
            hf = 1'b0;
            ln = LINE_BITS'(1);
        end

        n_mode      = m;
        n_hbyte     = hb;
        n_hkind     = hk;
        n_hvalid    = hv;
        n_hfirst    = hf;
        n_line      = ln;
        bun.res     = res;
        bun.count   = cnt;
    end

    assign o_push.valid = accept && (bun.count != '0);
    assign o_push.bun   = bun;

endmodule

// File: rtl/srctok_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// srctok_queue: bundle queue
// Short FIFO of result bundles between the scanner and the emitter.
// ============================================================================
module srctok_queue import srctok_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_full,
    output t_head   o_head
);

    t_bundle           r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [PTR_W:0]    r_cnt;
    logic              do_pop;

    assign o_full       = (r_cnt == (PTR_W + 1)'(QDEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.bun   = r_mem[r_rd];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) r_mem[r_wr] <= i_push.bun;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) r_wr <= r_wr + PTR_W'(1);
            if (do_pop)       r_rd <= r_rd + PTR_W'(1);
            if (i_push.valid && !do_pop)      r_cnt <= r_cnt + (PTR_W + 1)'(1);
            else if (do_pop && !i_push.valid) r_cnt <= r_cnt - (PTR_W + 1)'(1);
        end
    end

endmodule

// File: rtl/srctok_back.sv
`timescale 1ns / 1ps
// ============================================================================
// srctok_back: result emitter
// Walks the head bundle one result per unstalled cycle to the output register.
// ============================================================================
module srctok_back import srctok_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_head          i_head,
    output logic           o_pop,
    srctok_out_if.source   o_out
);

    logic [IDX_W-1:0] r_idx;
    logic             r_ov;
    t_result          r_res;
    logic             r_rl;
    logic             load;
    logic             at_end;

    assign load   = i_head.valid && (!r_ov || o_out.ready);
    assign at_end = ({1'b0, r_idx} == CNT_W'(i_head.bun.count - CNT_W'(1)));
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (load) begin
                r_ov  <= 1'b1;
                r_idx <= at_end ? '0 : r_idx + IDX_W'(1);
            end else if (o_out.ready) begin
                r_ov  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_head.bun.res[r_idx];
            r_rl  <= at_end;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.token_kind  = r_res.kind;
    assign o_out.text_byte   = r_res.text;
    assign o_out.text_valid  = r_res.text_valid;
    assign o_out.token_first = r_res.first;
    assign o_out.token_last  = r_res.last;
    assign o_out.line_number = r_res.line;
    assign o_out.error_code  = r_res.err;
    assign o_out.run_last    = r_rl;

endmodule

// File: rtl/source_tokenizer_top.sv
`timescale 1ns / 1ps
// ============================================================================
// source_tokenizer_top: source tokenizer
// Turns a stream of source bytes into token character beats tagged with
// kind, line and first/last marks; reports string and comment errors.
// ============================================================================
//
//  Channel  | Dir | Beat                                   | Handshake
//  ---------+-----+----------------------------------------+-----------
//  i_in     | in  | data_byte, is_last                     | valid/ready
//  o_out    | out | token_kind, text_byte, text_valid,     | valid/ready
//           |     | token_first, token_last, line_number,  |
//           |     | error_code, run_last                   |
//
//  Cycles: the scanner takes one byte per cycle; a byte with n results gives
//  n beats at the emitter, so bytes that average one result run back to back.
//  A byte's beats pass through the bundle queue and then the output register.
//  Stalls: the four-entry bundle queue absorbs bursts; the input drops ready
//  only while the queue is full.
//  Reset: synchronous, active low; clears mode, held char, line (to 1), queue.
//
module source_tokenizer_top import srctok_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srctok_in_if.sink     i_in,
    srctok_out_if.source  o_out
);

    // Scanner -> queue: results of one accepted byte
    t_push  push;
    // Queue -> emitter: oldest bundle
    t_head  head;
    logic   full;
    logic   pop;

    // Front: classify each byte, keep the held token char, build bundles
    srctok_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push)
    );

    // Decouple: hold bundles while the output side stalls
    srctok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // Back: drain each bundle beat by beat, mark the byte's last beat
    srctok_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// File: rtl/srctok_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// srctok_chk: port checker of the source tokenizer
// Watches the output beats for stall behavior and field consistency.
// ============================================================================
module srctok_chk import srctok_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic [4:0]  i_kind,
    input  logic [7:0]  i_text,
    input  logic        i_text_valid,
    input  logic        i_last,
    input  logic [15:0] i_line,
    input  logic [1:0]  i_err
);

    // Hold a stalled beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_text)
                                && $stable(i_line) && $stable(i_err))
        else $error("stalled output beat changed");

    a_text_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_text_valid |-> i_text == 8'h00)
        else $error("text byte set without text_valid");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_err != ERR_NONE |-> i_last && !i_text_valid
                                         && (i_kind == K_STRING || i_kind == K_EOF))
        else $error("error beat has wrong shape");

    // Line zero marks unknown bytes and nothing else
    a_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_line == 16'd0) == (i_kind == K_UNKNOWN)))
        else $error("line number zero does not match unknown kind");

endmodule

bind source_tokenizer_top srctok_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_kind       (o_out.token_kind),
    .i_text       (o_out.text_byte),
    .i_text_valid (o_out.text_valid),
    .i_last       (o_out.token_last),
    .i_line       (o_out.line_number),
    .i_err        (o_out.error_code)
);

// File: bench/tb_source_tokenizer_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_source_tokenizer_top: self-checking bench for the source tokenizer
// Feeds source texts byte by byte, predicts every token beat with a local
// scanner model and compares each output beat field by field, in order.
// ============================================================================
module tb_source_tokenizer_top;
    import srctok_pkg::*;

    typedef t_byte text_t[$];

    // One predicted output beat, run_last included
    typedef struct {
        t_kind       kind;
        t_byte       text;
        logic        text_valid;
        logic        first;
        logic        last;
        logic [15:0] line;
        t_err        err;
        logic        run_last;
    } tok_beat_t;

    localparam longint unsigned LINE_MAX = (64'd1 << LINE_BITS) - 64'd1;

    logic i_clk;
    logic i_rst_n;

    srctok_in_if  src_bus ();
    srctok_out_if tok_bus ();

    source_tokenizer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (src_bus),
        .o_out   (tok_bus)
    );

    // Shared between the byte sender, the beat receiver and the checker
    tok_beat_t pending_beats[$];
    tok_beat_t byte_beats[$];
    int        fail_count = 0;
    bit        idle_on    = 1'b1;
    int        sink_hold  = 0;

    // Scanner state of the local model
    t_mode             scan_st;
    t_byte             held_ch;
    t_kind             held_kind;
    logic              held_vld;
    logic              held_first;
    longint unsigned   line_cnt;
    logic              err_lock;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Token model
    // ------------------------------------------------------------------------
    function automatic logic ch_letter(t_byte b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic ch_digit(t_byte b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic ch_blank(t_byte b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
    endfunction

    // Kind of a lone punctuation byte, K_NONE otherwise
    function automatic t_kind punct_of(t_byte b);
        case (b)
            CH_LPAREN: return K_LPAREN;
            CH_RPAREN: return K_RPAREN;
            CH_LBRACK: return K_LBRACK;
            CH_RBRACK: return K_RBRACK;
            CH_LBRACE: return K_LBRACE;
            CH_RBRACE: return K_RBRACE;
            CH_COMMA:  return K_COMMA;
            CH_DOT:    return K_DOT;
            CH_COLON:  return K_COLON;
            CH_PLUS:   return K_PLUS;
            CH_STAR:   return K_STAR;
            CH_SLASH:  return K_SLASH;
            CH_EQ:     return K_ASSIGN;
            default:   return K_NONE;
        endcase
    endfunction

    function automatic void clear_scanner();
        scan_st    = M_IDLE;
        held_ch    = 8'h00;
        held_kind  = K_IDENT;
        held_vld   = 1'b0;
        held_first = 1'b0;
        line_cnt   = 1;
        err_lock   = 1'b0;
    endfunction

    function automatic void put_beat(t_kind k, t_byte ch, logic vld, logic fst, logic lst,
                                     longint unsigned ln, t_err e);
        tok_beat_t r;
        if (byte_beats.size() >= MAX_RES) return;
        r.kind       = k;
        r.text       = vld ? ch : 8'h00;
        r.text_valid = vld;
        r.first      = fst;
        r.last       = lst;
        r.line       = (ln > 65535) ? 16'hFFFF : 16'(ln);
        r.err        = e;
        r.run_last   = 1'b0;
        byte_beats.insert(byte_beats.size(), r);
    endfunction

    function automatic void bump_line();
        if (line_cnt < LINE_MAX) line_cnt++;
    endfunction

    // Send the held character, if any
    function automatic void release_held(logic lst);
        if (held_vld) put_beat(held_kind, held_ch, 1'b1, held_first, lst, line_cnt, ERR_NONE);
        held_vld = 1'b0;
    endfunction

    // Hold a new character; the previous one is now known not to be last
    function automatic void hold_char(t_byte b, t_kind k);
        logic fst;
        fst = !held_vld;
        release_held(1'b0);
        held_ch    = b;
        held_kind  = k;
        held_vld   = 1'b1;
        held_first = fst;
    endfunction

    function automatic void close_string();
        if (held_vld) release_held(1'b1);
        else put_beat(K_STRING, 8'h00, 1'b0, 1'b1, 1'b1, line_cnt, ERR_NONE);
    endfunction

    function automatic void put_eof(t_err e);
        put_beat(K_EOF, 8'h00, 1'b0, 1'b1, 1'b1, line_cnt, e);
    endfunction

    function automatic void put_pair(t_kind k, t_byte a, t_byte b);
        put_beat(k, a, 1'b1, 1'b1, 1'b0, line_cnt, ERR_NONE);
        put_beat(k, b, 1'b1, 1'b0, 1'b1, line_cnt, ERR_NONE);
        scan_st = M_IDLE;
    endfunction

    // First byte of a token, from idle
    function automatic void open_token(t_byte b);
        t_kind k;
        scan_st = M_IDLE;
        k = punct_of(b);
        if (ch_blank(b)) begin
            scan_st = M_GAP;
        end else if (ch_letter(b)) begin
            hold_char(b, K_IDENT);
            scan_st = M_IDENT;
        end else if (ch_digit(b)) begin
            hold_char(b, K_NUMBER);
            scan_st = M_NUM;
        end else if (b == CH_QUOTE) begin
            held_vld = 1'b0;
            scan_st  = M_STR;
        end else if (b == CH_CR || b == CH_LF) begin
            put_beat(K_SEP, CH_LF, 1'b1, 1'b1, 1'b1, line_cnt, ERR_NONE);
            bump_line();
            if (b == CH_CR) scan_st = M_CRTOK;
        end else if (b == CH_DASH) begin
            scan_st = M_DASH;
        end else if (b == CH_LT) begin
            scan_st = M_LT;
        end else if (b == CH_GT) begin
            scan_st = M_GT;
        end else if (k != K_NONE) begin
            put_beat(k, b, 1'b1, 1'b1, 1'b1, line_cnt, ERR_NONE);
        end else begin
            put_beat(K_UNKNOWN, 8'h00, 1'b0, 1'b1, 1'b1, 0, ERR_NONE);
        end
    endfunction

    function automatic void comment_line_byte(t_byte b);
        if (b == CH_CR) begin
            bump_line();
            scan_st = M_CRIGN;
        end else if (b == CH_LF) begin
            bump_line();
            scan_st = M_GAP;
        end else begin
            scan_st = M_LINE;
        end
    endfunction

    function automatic void comment_block_byte(t_byte b);
        if (b == CH_RBRACK) begin
            scan_st = M_BBR;
        end else if (b == CH_CR) begin
            bump_line();
            scan_st = M_BCR;
        end else begin
            if (b == CH_LF) bump_line();
            scan_st = M_BLOCK;
        end
    endfunction

    function automatic void scan_byte(t_byte b, logic lst);
        int unsigned esc;
        logic        fst;
        case (scan_st)
            M_IDENT: begin
                if (ch_letter(b) || ch_digit(b) || b == CH_UNDER) begin
                    hold_char(b, K_IDENT);
                end else begin
                    release_held(1'b1);
                    open_token(b);
                end
            end
            M_NUM: begin
                if (ch_digit(b)) begin
                    hold_char(b, K_NUMBER);
                end else if (b == CH_SLASH || b == CH_DOT) begin
                    hold_char(b, K_NUMBER);
                    scan_st = M_FRAC;
                end else begin
                    release_held(1'b1);
                    open_token(b);
                end
            end
            M_FRAC: begin
                if (ch_digit(b)) begin
                    hold_char(b, K_NUMBER);
                end else begin
                    release_held(1'b1);
                    open_token(b);
                end
            end
            M_STR: begin
                if (b == CH_QUOTE) begin
                    close_string();
                    scan_st = M_IDLE;
                end else if (b == CH_BSLASH) begin
                    scan_st = M_ESC;
                end else if (b == CH_CR || b == CH_LF) begin
                    // Raw newline: flush what is held, report, drop the rest
                    fst = !held_vld;
                    release_held(1'b0);
                    put_beat(K_STRING, 8'h00, 1'b0, fst, 1'b1, line_cnt, ERR_STR_NL);
                    err_lock = 1'b1;
                    scan_st  = M_ERR;
                end else begin
                    hold_char(b, K_STRING);
                end
            end
            M_ESC: begin
                esc = 256;
                if (b == CH_LC_T) esc = CH_TAB;
                else if (b == CH_LC_N) esc = CH_LF;
                else if (b == CH_LC_R) esc = CH_CR;
                else if (b == CH_BSLASH || b == CH_QUOTE) esc = b;
                if (esc < 256) hold_char(8'(esc), K_STRING);
                scan_st = M_STR;
            end
            M_CRTOK: begin
                if (b == CH_LF) scan_st = M_IDLE;
                else open_token(b);
            end
            M_CRIGN: begin
                if (b == CH_LF) scan_st = M_GAP;
                else open_token(b);
            end
            M_DASH: begin
                if (b == CH_GT) begin
                    put_pair(K_ARROW, CH_DASH, CH_GT);
                end else if (b == CH_DASH) begin
                    scan_st = M_DASH2;
                end else begin
                    put_beat(K_MINUS, CH_DASH, 1'b1, 1'b1, 1'b1, line_cnt, ERR_NONE);
                    open_token(b);
                end
            end
            M_LT: begin
                if (b == CH_EQ) begin
                    put_pair(K_LE, CH_LT, CH_EQ);
                end else begin
                    put_beat(K_LT, CH_LT, 1'b1, 1'b1, 1'b1, line_cnt, ERR_NONE);
                    open_token(b);
                end
            end
            M_GT: begin
                if (b == CH_EQ) begin
                    put_pair(K_GE, CH_GT, CH_EQ);
                end else begin
                    put_beat(K_GT, CH_GT, 1'b1, 1'b1, 1'b1, line_cnt, ERR_NONE);
                    open_token(b);
                end
            end
            M_DASH2: begin
                if (b == CH_LBRACK) scan_st = M_BR1;
                else comment_line_byte(b);
            end
            M_BR1: begin
                if (b == CH_LBRACK) scan_st = M_BLOCK;
                else comment_line_byte(b);
            end
            M_LINE: begin
                comment_line_byte(b);
            end
            M_BLOCK, M_BBR, M_BCR: begin
                // The closing bracket still counts on the final byte; newlines do not
                if (scan_st == M_BBR && b == CH_RBRACK) begin
                    scan_st = M_GAP;
                end else if (!lst) begin
                    if (scan_st == M_BCR && b == CH_LF) scan_st = M_BLOCK;
                    else comment_block_byte(b);
                end
            end
            default: begin
                open_token(b);
            end
        endcase
    endfunction

    // Close whatever is open when the text ends
    function automatic void end_of_text();
        case (scan_st)
            M_GAP, M_LINE, M_DASH2, M_BR1, M_CRIGN:
                put_eof(ERR_NONE);
            M_IDENT, M_NUM, M_FRAC:
                release_held(1'b1);
            M_STR, M_ESC:
                close_string();
            M_DASH:
                put_beat(K_MINUS, CH_DASH, 1'b1, 1'b1, 1'b1, line_cnt, ERR_NONE);
            M_LT:
                put_beat(K_LT, CH_LT, 1'b1, 1'b1, 1'b1, line_cnt, ERR_NONE);
            M_GT:
                put_beat(K_GT, CH_GT, 1'b1, 1'b1, 1'b1, line_cnt, ERR_NONE);
            M_BLOCK, M_BBR, M_BCR:
                put_eof(ERR_BLOCK_EOF);
            default: ;
        endcase
    endfunction

    // Work out the beats of one accepted byte and queue them
    function automatic void predict_tokens(t_byte b, logic lst);
        tok_beat_t r;
        byte_beats.delete();
        if (!err_lock) begin
            scan_byte(b, lst);
            if (lst) end_of_text();
        end
        if (lst) clear_scanner();
        if (byte_beats.size() > 0) begin
            r = byte_beats[byte_beats.size() - 1];
            r.run_last = 1'b1;
            byte_beats[byte_beats.size() - 1] = r;
        end
        foreach (byte_beats[i]) pending_beats.insert(pending_beats.size(), byte_beats[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------------
    // Valid stays high from one beat to the next unless a gap is drawn, so
    // it never gets two updates in one step.
    task automatic send_byte(t_byte b, logic lst);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            src_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_bus.valid     <= 1'b1;
        src_bus.data_byte <= b;
        src_bus.is_last   <= lst;
        do @(posedge i_clk); while (!src_bus.ready);
        predict_tokens(b, lst);
    endtask

    // Send one source text; its final byte carries the end mark
    task automatic send_text(text_t t);
        foreach (t[i]) send_byte(t[i], i == t.size() - 1);
    endtask

    task automatic send_str(string s);
        text_t t;
        for (int i = 0; i < s.len(); i++) t.insert(t.size(), s[i]);
        send_text(t);
    endtask

    // Hold the input idle until every predicted beat has come out, then
    // let the block settle
    task automatic wait_drained();
        src_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Beat receiver: random stalls per beat, plus a long hold on request
    // ------------------------------------------------------------------------
    initial begin : sink_side
        int gap;
        int hold_left;
        tok_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (sink_hold > 0) begin
                tok_bus.ready <= 1'b0;
                hold_left = sink_hold;
                sink_hold = 0;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
            end
            gap = idle_on ? $urandom_range(0, 14) : 0;
            if (gap > 0) begin
                tok_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            tok_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!tok_bus.valid);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every accepted beat against the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void note_field(string fname, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        tok_beat_t want;
        if (i_rst_n && tok_bus.valid && tok_bus.ready) begin
            if (pending_beats.size() == 0) begin
                $display("%0t ns: beat with no prediction, expected none, actual kind %0d",
                         $time, tok_bus.token_kind);
                fail_count++;
            end else begin
                want = pending_beats.pop_front();
                note_field("token_kind",  16'(want.kind),       16'(tok_bus.token_kind));
                note_field("text_byte",   16'(want.text),       16'(tok_bus.text_byte));
                note_field("text_valid",  16'(want.text_valid), 16'(tok_bus.text_valid));
                note_field("token_first", 16'(want.first),      16'(tok_bus.token_first));
                note_field("token_last",  16'(want.last),       16'(tok_bus.token_last));
                note_field("line_number", want.line,            tok_bus.line_number);
                note_field("error_code",  16'(want.err),        16'(tok_bus.error_code));
                note_field("run_last",    16'(want.run_last),   16'(tok_bus.run_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Random source texts
    // ------------------------------------------------------------------------
    function automatic t_byte rand_letter();
        return $urandom_range(0, 1) ? 8'(CH_UC_A + $urandom_range(0, 25))
                                    : 8'(CH_LC_A + $urandom_range(0, 25));
    endfunction

    function automatic t_byte rand_digit();
        return 8'(CH_0 + $urandom_range(0, 9));
    endfunction

    // Mostly well-formed tokens with random content; a few broken strings,
    // unclosed comments and raw noise bytes mixed in
    function automatic text_t random_text();
        text_t t;
        int    sel;
        int    n;
        t_byte c;
        string punct_set;
        string esc_set;
        punct_set = "()[]{},.:+*/=-<>";
        esc_set   = "tnr\\\"qx\n";
        repeat ($urandom_range(1, 8)) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                t.insert(t.size(), rand_letter());
                repeat ($urandom_range(0, 4)) begin
                    case ($urandom_range(0, 2))
                        0:       t.insert(t.size(), rand_letter());
                        1:       t.insert(t.size(), rand_digit());
                        default: t.insert(t.size(), CH_UNDER);
                    endcase
                end
            end else if (sel < 35) begin
                repeat ($urandom_range(1, 3)) t.insert(t.size(), rand_digit());
                if ($urandom_range(0, 1)) begin
                    t.insert(t.size(), $urandom_range(0, 1) ? CH_SLASH : CH_DOT);
                    repeat ($urandom_range(0, 2)) t.insert(t.size(), rand_digit());
                end
            end else if (sel < 45) begin
                t.insert(t.size(), CH_QUOTE);
                repeat ($urandom_range(0, 4)) begin
                    n = $urandom_range(0, 19);
                    if (n < 4) begin
                        t.insert(t.size(), CH_BSLASH);
                        t.insert(t.size(), esc_set[$urandom_range(0, 7)]);
                    end else if (n == 4) begin
                        t.insert(t.size(), $urandom_range(0, 1) ? CH_LF : CH_CR);
                    end else begin
                        c = 8'($urandom_range(32, 126));
                        if (c == CH_QUOTE || c == CH_BSLASH) c = CH_LC_A;
                        t.insert(t.size(), c);
                    end
                end
                if ($urandom_range(0, 9) != 0) t.insert(t.size(), CH_QUOTE);
            end else if (sel < 65) begin
                case ($urandom_range(0, 5))
                    0: begin t.insert(t.size(), CH_DASH); t.insert(t.size(), CH_GT); end
                    1: begin t.insert(t.size(), CH_LT);   t.insert(t.size(), CH_EQ); end
                    2: begin t.insert(t.size(), CH_GT);   t.insert(t.size(), CH_EQ); end
                    default: t.insert(t.size(), punct_set[$urandom_range(0, 15)]);
                endcase
            end else if (sel < 80) begin
                case ($urandom_range(0, 3))
                    0:       t.insert(t.size(), CH_SPACE);
                    1:       t.insert(t.size(), CH_TAB);
                    2:       t.insert(t.size(), CH_VT);
                    default: t.insert(t.size(), CH_FF);
                endcase
            end else if (sel < 88) begin
                case ($urandom_range(0, 2))
                    0:       t.insert(t.size(), CH_CR);
                    1:       t.insert(t.size(), CH_LF);
                    default: begin t.insert(t.size(), CH_CR); t.insert(t.size(), CH_LF); end
                endcase
            end else if (sel < 94) begin
                t.insert(t.size(), CH_DASH);
                t.insert(t.size(), CH_DASH);
                if ($urandom_range(0, 1)) begin
                    t.insert(t.size(), CH_LBRACK);
                    t.insert(t.size(), CH_LBRACK);
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(0, 4))
                            0:       t.insert(t.size(), CH_LF);
                            1:       t.insert(t.size(), CH_CR);
                            2:       t.insert(t.size(), CH_RBRACK);
                            default: t.insert(t.size(), 8'($urandom_range(32, 126)));
                        endcase
                    end
                    if ($urandom_range(0, 7) != 0) begin
                        t.insert(t.size(), CH_RBRACK);
                        t.insert(t.size(), CH_RBRACK);
                    end
                end else begin
                    repeat ($urandom_range(0, 5)) t.insert(t.size(), 8'($urandom_range(32, 126)));
                    case ($urandom_range(0, 2))
                        0:       t.insert(t.size(), CH_LF);
                        1:       t.insert(t.size(), CH_CR);
                        default: begin t.insert(t.size(), CH_CR); t.insert(t.size(), CH_LF); end
                    endcase
                end
            end else begin
                t.insert(t.size(), 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1)) t.insert(t.size(), CH_SPACE);
        end
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Identifiers, a number with '/' ended by a '.', and every two-char operator
    task automatic test_tokens();
        send_str("Az_9 0/1.5<=>=->");
        send_str("(-<>)");
        wait_drained();
    endtask

    // Escapes, empty string, unterminated string, backslash as final byte
    task automatic test_strings();
        send_str("\"\\t\\n\\r\\\\\\\"\\q\\\n\"\"");
        send_str("\"a\\");
        wait_drained();
    endtask

    // CR, LF and CR LF separators, then a raw newline inside a string
    task automatic test_lines_and_errors();
        send_str("a\r\nb\rc\n\"x\ny");
        wait_drained();
    endtask

    // Line comment, block comment over CR LF, block left open at the end
    task automatic test_comments();
        send_str("--x\n--[[\r\n]]--[[\n");
        wait_drained();
    endtask

    // Extreme and unknown bytes, in a text ending in a blank
    task automatic test_unknown_bytes();
        text_t t;
        t = '{8'h00, 8'hFF, CH_UNDER, 8'h80, CH_SPACE};
        send_text(t);
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while bytes keep coming, so the
    // bundle queue fills and the input stalls
    task automatic test_backpressure();
        idle_on   = 1'b0;
        sink_hold = 300;
        send_str("((((((((((->->->->->(((((<=<=<=)");
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_sources();
        text_t t;
        int    sent;
        sent = 0;
        while (sent < 200) begin
            // Mostly idling on both sides, with stretches at full rate
            idle_on = ($urandom_range(0, 4) != 0);
            t = random_text();
            send_text(t);
            sent += t.size();
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    initial begin : run_tests
        i_rst_n           <= 1'b0;
        src_bus.valid     <= 1'b0;
        src_bus.data_byte <= 8'h00;
        src_bus.is_last   <= 1'b0;
        clear_scanner();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tokens();
        test_strings();
        test_lines_and_errors();
        test_comments();
        test_unknown_bytes();
        test_backpressure();
        test_random_sources();

        if (fail_count == 0 && pending_beats.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/srctok_pkg.sv
rtl/srctok_if.sv
rtl/srctok_front.sv
rtl/srctok_queue.sv
rtl/srctok_back.sv
rtl/source_tokenizer_top.sv
rtl/srctok_chk.sv
bench/tb_source_tokenizer_top.sv
